// File: rtl/mmbd_pkg.sv
// ----------------------------------------------------------------------------
// mmbd_pkg
// Shared types, constants and channel arithmetic for the mip level
// downsampler.
// ----------------------------------------------------------------------------
package mmbd_pkg;

  localparam int unsigned PIX_W      = 32;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = 4;
  localparam int unsigned PSUM_W     = 10;
  localparam int unsigned PAIR_W     = NUM_CHAN * PSUM_W;
  localparam int unsigned REG_W      = 13;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned HEIGHT_MAX = 4096;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [PAIR_W-1:0] pair_t;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_SRC_WIDTH  = 8'd0,
    CFG_SRC_HEIGHT = 8'd1
  } cfg_idx_e;

  // Request from the front end to the averaging stage
  typedef struct packed {
    logic  valid;
    logic  single_row;
    logic  last;
    pair_t pair;
  } mmbd_req_t;

  // Per-channel sum of two pixels, four 10-bit fields
  function automatic pair_t pair_add(input pixel_t a, input pixel_t b);
    pair_t r;
    r = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      r[c*PSUM_W +: PSUM_W] = PSUM_W'(a[c*CHAN_W +: CHAN_W])
                            + PSUM_W'(b[c*CHAN_W +: CHAN_W]);
    end
    return r;
  endfunction

  // Per-channel floor((p + q) / 4), repacked as 8-bit channels
  function automatic pixel_t quad_avg(input pair_t p, input pair_t q);
    pixel_t               r;
    logic [PSUM_W:0]      s;
    r = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      s = (PSUM_W+1)'(p[c*PSUM_W +: PSUM_W]) + (PSUM_W+1)'(q[c*PSUM_W +: PSUM_W]);
      r[c*CHAN_W +: CHAN_W] = s[CHAN_W+1:2];
    end
    return r;
  endfunction

endpackage

// File: rtl/mipmap_box_downsample.sv
// A 2x2 block's request registers in s1, then in the output register.
// Throughput: one source pixel per cycle while the sink takes results; the
// line store has one write and one read port, enough for one pixel a cycle.
// Reset: position counters and left pixel cleared, width and height set to 1.
// The line store is not cleared; every entry is written before it is read.
// ----------------------------------------------------------------------------
// mipmap_box_downsample
// One mip level of a 2x2 box filter over a raster RGBA pixel stream.
// ----------------------------------------------------------------------------
module mipmap_box_downsample #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // source pixels
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // [31:0] pixel
  // downsampled pixels
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,  // [31:0] out_pixel
  output logic                        m_axis_tlast,  // last_of_level
  // configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mmbd_pkg::IDX_W-1:0]  cfg_index_i,
  input  logic [mmbd_pkg::REG_W-1:0]  cfg_data_i
);

  localparam int unsigned DEPTH  = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mmbd_pkg::mmbd_req_t req;
  mmbd_pkg::pair_t     wr_data, rd_data;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic                wr_en, rd_en, free, accept;

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;
  assign cfg_ready_o   = 1'b1;

  mmbd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .pixel_i     (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_o       (req),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr)
  );

  mmbd_line_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (mmbd_pkg::PAIR_W),
    .ADDR_W (ADDR_W)
  ) u_line (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  mmbd_avg_out u_avg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .rd_data_i     (rd_data),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: rtl/mmbd_line_ram.sv
// ----------------------------------------------------------------------------
// mmbd_line_ram
// Line store for even-row pair sums: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mmbd_line_ram #(
  parameter int unsigned DEPTH  = 2048,
  parameter int unsigned DATA_W = 40,
  parameter int unsigned ADDR_W = 11
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held when not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// File: rtl/mmbd_front.sv
// ----------------------------------------------------------------------------
// mmbd_front
// Raster position counters, horizontal pair sums and line store control.
// ----------------------------------------------------------------------------
module mmbd_front #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned ADDR_W    = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  mmbd_pkg::pixel_t          pixel_i,
  input  logic                      cfg_we_i,
  input  logic [mmbd_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [mmbd_pkg::REG_W-1:0] cfg_data_i,
  output mmbd_pkg::mmbd_req_t       req_o,
  output logic                      wr_en_o,
  output logic [ADDR_W-1:0]         wr_addr_o,
  output mmbd_pkg::pair_t           wr_data_o,
  output logic                      rd_en_o,
  output logic [ADDR_W-1:0]         rd_addr_o
);

  localparam int unsigned CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned EW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = mmbd_pkg::REG_W;

  logic [mmbd_pkg::REG_W-1:0] src_w_q, src_w_d;
  logic [mmbd_pkg::REG_W-1:0] src_h_q, src_h_d;
  logic [CW-1:0]              col_q, col_d;
  logic [mmbd_pkg::ROW_W-1:0] row_q, row_d;
  mmbd_pkg::pixel_t           left_q, left_d;

  logic [31:0]   w_ext;
  logic [EW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [EW-1:0] half_w, ow_m1;
  logic [HW-1:0] half_h, oh_m1;
  logic          w_one, h_one, have_pair, row_odd, emit, col_end, row_end, is_last;
  mmbd_pkg::pair_t pair;

  // effective sizes after clamping
  always_comb begin
    w_ext = 32'(src_w_q);
    if (w_ext == 32'd0) begin
      w_ext = 32'd1;
    end else if (w_ext > 32'(MAX_WIDTH)) begin
      w_ext = 32'(MAX_WIDTH);
    end
    eff_w = w_ext[EW-1:0];
    if (src_h_q == '0) begin
      eff_h = HW'(1);
    end else if (src_h_q > HW'(mmbd_pkg::HEIGHT_MAX)) begin
      eff_h = HW'(mmbd_pkg::HEIGHT_MAX);
    end else begin
      eff_h = src_h_q;
    end
    half_w = eff_w >> 1;
    half_h = eff_h >> 1;
    ow_m1  = (half_w == '0) ? '0 : half_w - EW'(1);
    oh_m1  = (half_h == '0) ? '0 : half_h - HW'(1);
  end

  // position decode and pair sum
  always_comb begin
    w_one     = (eff_w == EW'(1));
    h_one     = (eff_h == HW'(1));
    row_odd   = row_q[0];
    have_pair = w_one || col_q[0];
    emit      = have_pair && (h_one || row_odd);
    pair      = w_one ? mmbd_pkg::pair_add(pixel_i, pixel_i)
                      : mmbd_pkg::pair_add(left_q, pixel_i);
    col_end   = (EW'(col_q) + EW'(1)) >= eff_w;
    row_end   = (HW'(row_q) + HW'(1)) >= eff_h;
    is_last   = (EW'(col_q >> 1) == ow_m1) && (HW'(row_q >> 1) == oh_m1);
  end

  // line store access: write on even rows with a row below, read on odd rows
  assign wr_en_o   = accept_i && have_pair && !h_one && !row_odd
                     && (HW'(row_q) < (eff_h - HW'(1)));
  assign wr_addr_o = ADDR_W'(col_q >> 1);
  assign wr_data_o = pair;
  assign rd_en_o   = accept_i && have_pair && !h_one && row_odd;
  assign rd_addr_o = ADDR_W'(col_q >> 1);

  // request to the averaging stage
  always_comb begin
    req_o.valid      = accept_i && emit;
    req_o.single_row = h_one;
    req_o.last       = is_last;
    req_o.pair       = pair;
  end

  // next state: writes to either size register restart the frame
  always_comb begin
    src_w_d = src_w_q;
    src_h_d = src_h_q;
    col_d   = col_q;
    row_d   = row_q;
    left_d  = left_q;
    if (cfg_we_i) begin
      priority if (cfg_index_i == mmbd_pkg::CFG_SRC_WIDTH) begin
        src_w_d = cfg_data_i;
        col_d   = '0;
        row_d   = '0;
        left_d  = '0;
      end else if (cfg_index_i == mmbd_pkg::CFG_SRC_HEIGHT) begin
        src_h_d = cfg_data_i;
        col_d   = '0;
        row_d   = '0;
        left_d  = '0;
      end else begin
        src_w_d = src_w_q;
      end
    end else if (accept_i) begin
      if (!have_pair) begin
        left_d = pixel_i;
      end
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + mmbd_pkg::ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= mmbd_pkg::REG_W'(1);
      src_h_q <= mmbd_pkg::REG_W'(1);
      col_q   <= '0;
      row_q   <= '0;
      left_q  <= '0;
    end else begin
      src_w_q <= src_w_d;
      src_h_q <= src_h_d;
      col_q   <= col_d;
      row_q   <= row_d;
      left_q  <= left_d;
    end
  end

endmodule

// File: rtl/mmbd_avg_out.sv
// ----------------------------------------------------------------------------
// mmbd_avg_out
// Joins the stored pair sum with the current one, averages, and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module mmbd_avg_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mmbd_pkg::mmbd_req_t req_i,
  input  mmbd_pkg::pair_t     rd_data_i,
  output logic                free_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output mmbd_pkg::pixel_t    m_axis_tdata,
  output logic                m_axis_tlast
);

  logic             s1_v_q, s1_v_d;
  logic             s1_single_q;
  logic             s1_last_q;
  mmbd_pkg::pair_t  s1_pair_q;
  logic             out_v_q, out_v_d;
  mmbd_pkg::pixel_t out_pix_q;
  logic             out_last_q;
  logic             out_free, s1_move;
  mmbd_pkg::pixel_t avg;

  assign out_free = !out_v_q || m_axis_tready;
  assign s1_move  = s1_v_q && out_free;
  assign free_o   = !s1_v_q || out_free;

  // average: a single-row level reuses its own pair
  assign avg = mmbd_pkg::quad_avg(s1_single_q ? s1_pair_q : rd_data_i, s1_pair_q);

  // valid flags
  always_comb begin
    s1_v_d  = s1_v_q;
    out_v_d = out_v_q;
    if (s1_move || !s1_v_q) begin
      s1_v_d = req_i.valid;
    end
    if (out_free) begin
      out_v_d = s1_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      s1_single_q <= req_i.single_row;
      s1_last_q   <= req_i.last;
      s1_pair_q   <= req_i.pair;
    end
    if (s1_move) begin
      out_pix_q  <= avg;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2x2 box filter mip level downsampler. Source
// pixels stream in under a range of sizes and stall patterns; a predictor
// built into the bench forms every expected mip pixel and end-of-level flag
// and the monitor compares each result as it leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned MAX_W          = 4096;
  localparam int unsigned LINE_DEPTH     = MAX_W / 2;
  localparam time         CLK_HALF       = 2ns;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned END_CYCLES     = 16;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned RANDOM_ITEMS   = 270;
  localparam int unsigned TAIL_ITEMS     = 32;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  // register indexes past the end of the register list
  localparam logic [mmbd_pkg::IDX_W-1:0] IDX_UNUSED_LO = 8'd2;
  localparam logic [mmbd_pkg::IDX_W-1:0] IDX_UNUSED_HI = 8'hFF;

  typedef struct {
    mmbd_pkg::pixel_t px;
    logic             last;
  } mip_pixel_t;

  logic                         clk_i;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [31:0]                  s_axis_tdata  = '0;   // [31:0] pixel
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [31:0]                  m_axis_tdata;         // [31:0] out_pixel
  logic                         m_axis_tlast;         // last_of_level
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  logic [mmbd_pkg::IDX_W-1:0]   cfg_index_i   = '0;
  logic [mmbd_pkg::REG_W-1:0]   cfg_data_i    = '0;

  // stimulus and expectation stores
  mmbd_pkg::pixel_t source_pixels[$];
  mip_pixel_t       pending_mip_pixels[$];

  // predictor state
  logic [mmbd_pkg::REG_W-1:0] reg_width  = 13'd1;
  logic [mmbd_pkg::REG_W-1:0] reg_height = 13'd1;
  mmbd_pkg::pixel_t           left_pix   = '0;
  int unsigned                col_pos    = 0;
  int unsigned                row_pos    = 0;
  mmbd_pkg::pair_t            line_sums[LINE_DEPTH];

  // handshakes seen at the last rising edge
  logic pix_fire = 1'b0;
  logic out_fire = 1'b0;
  logic cfg_fire = 1'b0;

  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct  = 0;
  int unsigned hold_len        = 0;
  int unsigned hold_left       = 0;
  bit          hold_taken      = 1'b0;

  int unsigned errors       = 0;
  int unsigned pixels_in    = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes   = 0;
  int unsigned phase_no     = 0;
  int unsigned stall_cycles = 0;

  mipmap_box_downsample #(
    .MAX_WIDTH(MAX_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #(CLK_HALF);
    clk_i = 1'b0;
    #(CLK_HALF);
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // zero reads as one, anything past the limit reads as the limit
  function automatic int unsigned eff_size(input logic [mmbd_pkg::REG_W-1:0] val,
                                           input int unsigned limit);
    int unsigned s;
    s = val;
    if (s == 0) s = 1;
    if (s > limit) s = limit;
    return s;
  endfunction

  // four 10-bit channel sums of a horizontal pair
  function automatic mmbd_pkg::pair_t add_pixel_pair(input mmbd_pkg::pixel_t a,
                                                     input mmbd_pkg::pixel_t b);
    mmbd_pkg::pair_t acc;
    acc = '0;
    for (int ch = 0; ch < mmbd_pkg::NUM_CHAN; ch++) begin
      acc[ch*mmbd_pkg::PSUM_W +: mmbd_pkg::PSUM_W] =
          {2'b00, a[ch*mmbd_pkg::CHAN_W +: mmbd_pkg::CHAN_W]}
        + {2'b00, b[ch*mmbd_pkg::CHAN_W +: mmbd_pkg::CHAN_W]};
    end
    return acc;
  endfunction

  // floor of the four-pixel mean, per channel
  function automatic mmbd_pkg::pixel_t block_mean(input mmbd_pkg::pair_t upper,
                                                  input mmbd_pkg::pair_t lower);
    mmbd_pkg::pixel_t          res;
    logic [mmbd_pkg::PSUM_W:0] total;
    res = '0;
    for (int ch = 0; ch < mmbd_pkg::NUM_CHAN; ch++) begin
      total = {1'b0, upper[ch*mmbd_pkg::PSUM_W +: mmbd_pkg::PSUM_W]}
            + {1'b0, lower[ch*mmbd_pkg::PSUM_W +: mmbd_pkg::PSUM_W]};
      res[ch*mmbd_pkg::CHAN_W +: mmbd_pkg::CHAN_W] = total[mmbd_pkg::PSUM_W-1:2];
    end
    return res;
  endfunction

  function automatic void predict_level_pixel(input mmbd_pkg::pixel_t px);
    int unsigned     w;
    int unsigned     h;
    int unsigned     ow;
    int unsigned     oh;
    int unsigned     ox;
    int unsigned     oy;
    bit              have;
    bit              emit;
    mmbd_pkg::pair_t pair;
    mip_pixel_t      res;
    w    = eff_size(reg_width, MAX_W);
    h    = eff_size(reg_height, mmbd_pkg::HEIGHT_MAX);
    ow   = (w / 2 > 0) ? w / 2 : 1;
    oh   = (h / 2 > 0) ? h / 2 : 1;
    have = 1'b0;
    emit = 1'b0;
    pair = '0;
    res  = '{px: '0, last: 1'b0};

    // horizontal pair: a single column pairs with itself
    if (w == 1) begin
      pair = add_pixel_pair(px, px);
      have = 1'b1;
    end else if (col_pos[0]) begin
      pair = add_pixel_pair(left_pix, px);
      have = 1'b1;
    end else begin
      left_pix = px;
    end

    // vertical pair: even rows park in the line store, odd rows complete
    if (have) begin
      ox = col_pos / 2;
      oy = row_pos / 2;
      if (ox < LINE_DEPTH) begin
        if (h == 1) begin
          res.px = block_mean(pair, pair);
          emit   = 1'b1;
        end else if (row_pos[0]) begin
          res.px = block_mean(line_sums[ox], pair);
          emit   = 1'b1;
        end else if (row_pos < h - 1) begin
          line_sums[ox] = pair;
        end
      end
      if (emit) begin
        res.last = (ox == ow - 1) && (oy == oh - 1);
        pending_mip_pixels.insert(pending_mip_pixels.size(), res);
      end
    end

    // raster position, wrapping at the frame end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: checks results, feeds the predictor, tracks register writes
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_outputs
    mip_pixel_t want;
    if (!rst_ni) begin
      pix_fire <= 1'b0;
      out_fire <= 1'b0;
      cfg_fire <= 1'b0;
    end else begin
      pix_fire <= s_axis_tvalid && s_axis_tready;
      out_fire <= m_axis_tvalid && m_axis_tready;
      cfg_fire <= cfg_valid_i && cfg_ready_o;

      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_mip_pixels.size() == 0) begin
          $error("unexpected result: out_pixel %h last_of_level %b",
                 m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          want = pending_mip_pixels.pop_front();
          if (m_axis_tdata !== want.px) begin
            $error("out_pixel: expected %h, actual %h", want.px, m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_of_level: expected %b, actual %b", want.last, m_axis_tlast);
            errors++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        predict_level_pixel(s_axis_tdata);
        pixels_in++;
      end

      // a write to either size register restarts the frame
      if (cfg_valid_i && cfg_ready_o) begin
        reg_writes++;
        unique case (cfg_index_i)
          mmbd_pkg::CFG_SRC_WIDTH: begin
            reg_width = cfg_data_i;
            col_pos   = 0;
            row_pos   = 0;
            left_pix  = '0;
          end
          mmbd_pkg::CFG_SRC_HEIGHT: begin
            reg_height = cfg_data_i;
            col_pos    = 0;
            row_pos    = 0;
            left_pix   = '0;
          end
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: no request moving for too long ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watchdog
    if (pix_fire || out_fire || cfg_fire || !rst_ni) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Source driver
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_pixels
    logic slot_free;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      slot_free = !s_axis_tvalid || pix_fire;
      if (slot_free) begin
        if (source_pixels.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_axis_tdata  <= source_pixels.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink: random stalls plus one long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_sink
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (!hold_taken && hold_len != 0) begin
      hold_left     = hold_len;
      hold_taken    = 1'b1;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [mmbd_pkg::IDX_W-1:0] idx,
                           input logic [mmbd_pkg::REG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_size(input int unsigned w, input int unsigned h);
    write_reg(mmbd_pkg::CFG_SRC_WIDTH, w[mmbd_pkg::REG_W-1:0]);
    write_reg(mmbd_pkg::CFG_SRC_HEIGHT, h[mmbd_pkg::REG_W-1:0]);
  endtask

  // rotate through no idling, idle sender, stalling sink, and both
  task automatic next_idling();
    case (phase_no % 4)
      0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin sender_idle_pct = 80; sink_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  sink_stall_pct = 80; end
      default: begin sender_idle_pct = 13; sink_stall_pct = 13; end
    endcase
    phase_no++;
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) source_pixels.insert(source_pixels.size(), $urandom());
  endtask

  // all pixels taken, all results in, then room for trailing work
  task automatic wait_idle();
    do @(posedge clk_i);
    while (source_pixels.size() != 0 || s_axis_tvalid || pending_mip_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned random_items;
    random_items = 0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset size is 1x1: every pixel comes back unchanged and flagged last
    next_idling();
    source_pixels = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0102_0304, 32'h80FF_7F00};
    wait_idle();

    // zero sizes read as one
    next_idling();
    set_size(0, 0);
    source_pixels = '{32'hA5A5_5A5A, 32'h5A5A_A5A5};
    wait_idle();

    // 3x3: trailing column and row dropped, then the first row of a new frame
    next_idling();
    set_size(3, 3);
    source_pixels = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678,
                      32'hFFFF_FFFF, 32'hFEFE_FEFE, 32'h8765_4321,
                      32'hDEAD_BEEF, 32'h0BAD_F00D, 32'hC0FF_EE00,
                      32'h0101_0101, 32'h0202_0202, 32'h7777_7777};
    wait_idle();

    // writes past the register list change nothing, so the frame carries on
    next_idling();
    write_reg(IDX_UNUSED_LO, 13'h1FFF);
    write_reg(IDX_UNUSED_HI, 13'h1FFF);
    source_pixels = '{32'h0303_0303, 32'h0404_0404, 32'h5555_AAAA,
                      32'hAAAA_5555, 32'h0F0F_F0F0, 32'hF0F0_0F0F};
    wait_idle();

    // single column used twice
    next_idling();
    set_size(1, 2);
    source_pixels = '{32'hFF00_FF00, 32'h00FF_00FF};
    wait_idle();

    // long sink hold-off while the source keeps offering
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    set_size(8, 8);
    hold_len = HOLD_CYCLES;
    push_random(128);
    wait_idle();

    // random sizes: mostly whole frames, some cut short by the next write
    while (random_items < RANDOM_ITEMS) begin
      w = $urandom_range(0, 12);
      if ($urandom_range(7) == 0) w = $urandom_range(13, 40);
      h = $urandom_range(0, 9);
      next_idling();
      set_size(w, h);
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      n = $urandom_range(1, 3) * w * h;
      if ($urandom_range(3) == 0) n += $urandom_range(1, w * h);
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
      push_random(n);
      random_items += n;
      wait_idle();
    end

    // oversize width write: clamped to the maximum, start of the first row
    next_idling();
    set_size(13'h1FFF, 2);
    push_random(TAIL_ITEMS);
    wait_idle();

    // exact maximum width, one row, partial
    next_idling();
    set_size(MAX_W, 1);
    push_random(TAIL_ITEMS);
    wait_idle();

    // single column at full height, first rows only
    next_idling();
    set_size(1, mmbd_pkg::HEIGHT_MAX);
    push_random(TAIL_ITEMS);
    wait_idle();

    // both sizes oversize: start of the first row
    next_idling();
    set_size(MAX_W + 1, 13'h1FFF);
    push_random(TAIL_ITEMS);
    wait_idle();

    repeat (END_CYCLES) @(negedge clk_i);
    $display("tb: %0d source pixels in, %0d mip pixels checked, %0d register writes",
             pixels_in, results_seen, reg_writes);
    $display("tb: zero, odd, single line and oversize sizes, stalls on both sides");
    if (errors == 0 && pending_mip_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
